// File: rtl/button_debounce_gesture_detector_macros.svh
// Assertion macros for the button debounce and gesture detector.
`ifndef BUTTON_DEBOUNCE_GESTURE_DETECTOR_MACROS_SVH
`define BUTTON_DEBOUNCE_GESTURE_DETECTOR_MACROS_SVH

`ifndef SYNTH
`define BDG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdg assertion failed");
`define BDG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdg assertion failed");
`else
`define BDG_ASSERT_NOW(label, ante, cons)
`define BDG_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/bdg_pkg.sv
package bdg_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam logic [7:0] COUNT_MAX = 8'd255;
    localparam logic [7:0] DOUBLE_CLICKS = 8'd2;

    typedef enum logic [2:0] {
        REG_DEBOUNCE     = 3'd0,
        REG_MIN_PRESS    = 3'd1,
        REG_MAX_PRESS    = 3'd2,
        REG_MAX_INTERVAL = 3'd3,
        REG_LONG_PRESS   = 3'd4,
        REG_REPEAT_LONG  = 3'd5,
        REG_EVENTS_ON    = 3'd6,
        REG_EVENT_MASK   = 3'd7
    } reg_index_t;

    localparam int unsigned MASK_CHANGE = 0;
    localparam int unsigned MASK_RISE   = 1;
    localparam int unsigned MASK_FALL   = 2;
    localparam int unsigned MASK_SINGLE = 3;
    localparam int unsigned MASK_DOUBLE = 4;
    localparam int unsigned MASK_LONG   = 5;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] min_press_ms;
        logic [15:0] max_press_ms;
        logic [15:0] max_interval_ms;
        logic [15:0] long_press_ms;
        logic        repeat_long;
        logic        events_on;
        logic [5:0]  event_mask;
    } cfg_t;

    typedef struct packed {
        logic        raw_level;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic stable_level;
        logic prior_level;
        logic change_event;
        logic rise_event;
        logic fall_event;
        logic single_event;
        logic double_event;
        logic long_event;
    } out_item_t;

endpackage

// File: rtl/bdg_cfg_regs.sv
module bdg_cfg_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [bdg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output bdg_pkg::cfg_t             cfg
);

    bdg_pkg::cfg_t      cfg_reg;
    bdg_pkg::reg_index_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = bdg_pkg::reg_index_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms     <= 16'd50;
            cfg_reg.min_press_ms    <= 16'd50;
            cfg_reg.max_press_ms    <= 16'd1000;
            cfg_reg.max_interval_ms <= 16'd300;
            cfg_reg.long_press_ms   <= 16'd1000;
            cfg_reg.repeat_long     <= 1'b0;
            cfg_reg.events_on       <= 1'b1;
            cfg_reg.event_mask      <= 6'd0;
        end
        else if (wr_en)
        begin
            case (idx)
                bdg_pkg::REG_DEBOUNCE:     cfg_reg.debounce_ms     <= pwdata[15:0];
                bdg_pkg::REG_MIN_PRESS:    cfg_reg.min_press_ms    <= pwdata[15:0];
                bdg_pkg::REG_MAX_PRESS:    cfg_reg.max_press_ms    <= pwdata[15:0];
                bdg_pkg::REG_MAX_INTERVAL: cfg_reg.max_interval_ms <= pwdata[15:0];
                bdg_pkg::REG_LONG_PRESS:   cfg_reg.long_press_ms   <= pwdata[15:0];
                bdg_pkg::REG_REPEAT_LONG:  cfg_reg.repeat_long     <= pwdata[0];
                bdg_pkg::REG_EVENTS_ON:    cfg_reg.events_on       <= pwdata[0];
                bdg_pkg::REG_EVENT_MASK:   cfg_reg.event_mask      <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            bdg_pkg::REG_DEBOUNCE:     prdata = {16'd0, cfg_reg.debounce_ms};
            bdg_pkg::REG_MIN_PRESS:    prdata = {16'd0, cfg_reg.min_press_ms};
            bdg_pkg::REG_MAX_PRESS:    prdata = {16'd0, cfg_reg.max_press_ms};
            bdg_pkg::REG_MAX_INTERVAL: prdata = {16'd0, cfg_reg.max_interval_ms};
            bdg_pkg::REG_LONG_PRESS:   prdata = {16'd0, cfg_reg.long_press_ms};
            bdg_pkg::REG_REPEAT_LONG:  prdata = {31'd0, cfg_reg.repeat_long};
            bdg_pkg::REG_EVENTS_ON:    prdata = {31'd0, cfg_reg.events_on};
            bdg_pkg::REG_EVENT_MASK:   prdata = {26'd0, cfg_reg.event_mask};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

// File: rtl/bdg_step.sv
module bdg_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  bdg_pkg::in_item_t    item,
    input  bdg_pkg::cfg_t        cfg,
    output bdg_pkg::out_item_t   result
);

    logic        debounced_reg, debounced_next;
    logic        prev_raw_reg;
    logic [31:0] raw_change_time_reg, raw_change_time_next;
    logic [31:0] press_start_reg, press_start_next;
    logic        press_pending_reg, press_pending_next;
    logic [31:0] last_click_time_reg, last_click_time_next;
    logic [7:0]  click_count_reg, click_count_next;
    logic        long_fired_reg, long_fired_next;

    logic        raw;
    logic [31:0] now;
    logic        raw_changed, accept, fall_edge;
    logic [31:0] stable_time, press_dur, gap;
    logic        pending_a;
    logic [7:0]  count_a, count_b;
    logic        has_single, has_double, has_long;
    logic        click_ok, click_taken;
    logic        ev_single, ev_double, ev_long;

    assign raw = item.raw_level;
    assign now = item.now_ms;
    assign has_single = cfg.event_mask[bdg_pkg::MASK_SINGLE];
    assign has_double = cfg.event_mask[bdg_pkg::MASK_DOUBLE];
    assign has_long   = cfg.event_mask[bdg_pkg::MASK_LONG];

    always_comb
    begin
        // debounce
        raw_changed          = (raw != prev_raw_reg);
        raw_change_time_next = raw_changed ? now : raw_change_time_reg;
        stable_time          = raw_changed ? 32'd0 : (now - raw_change_time_reg);
        accept               = (stable_time > {16'd0, cfg.debounce_ms}) && (raw != debounced_reg);
        debounced_next       = accept ? raw : debounced_reg;
        fall_edge            = accept && !raw;
        press_start_next     = fall_edge ? now : press_start_reg;
        pending_a            = fall_edge ? 1'b1 : press_pending_reg;
        count_a              = (fall_edge && (click_count_reg != bdg_pkg::COUNT_MAX))
                               ? click_count_reg + 8'd1 : click_count_reg;
        press_dur            = fall_edge ? 32'd0 : (now - press_start_reg);
        gap                  = now - last_click_time_reg;

        long_fired_next      = long_fired_reg;
        press_pending_next   = pending_a;
        last_click_time_next = last_click_time_reg;
        click_count_next     = count_a;
        count_b              = count_a;
        click_ok             = 1'b0;
        click_taken          = 1'b0;
        ev_single            = 1'b0;
        ev_double            = 1'b0;
        ev_long              = 1'b0;

        if (cfg.events_on)
        begin
            // long press
            if (!debounced_next && has_long)
            begin
                if ((press_dur >= {16'd0, cfg.long_press_ms}) &&
                    (cfg.repeat_long || !long_fired_reg))
                begin
                    ev_long         = 1'b1;
                    long_fired_next = 1'b1;
                end
            end
            else
            begin
                long_fired_next = 1'b0;
            end

            // release classification
            if (debounced_next && pending_a)
            begin
                click_ok = (press_dur >= {16'd0, cfg.min_press_ms}) &&
                           (press_dur <= {16'd0, cfg.max_press_ms});
                if (click_ok)
                begin
                    if ((count_a == bdg_pkg::DOUBLE_CLICKS) && has_double)
                    begin
                        if (gap <= {16'd0, cfg.max_interval_ms})
                        begin
                            ev_double = 1'b1;
                            count_b   = 8'd0;
                        end
                        else
                        begin
                            ev_single = has_single;
                            count_b   = 8'd1;
                        end
                    end
                    else if ((count_a == 8'd1) && !has_double)
                    begin
                        ev_single = has_single;
                        count_b   = 8'd0;
                    end
                    last_click_time_next = now;
                    click_taken          = 1'b1;
                end
                else if (press_dur > {16'd0, cfg.max_press_ms})
                begin
                    count_b = 8'd0;
                end
                press_pending_next = 1'b0;
            end

            // single click timeout
            click_count_next = count_b;
            if (debounced_next && (count_b == 8'd1) && has_double && !press_pending_next)
            begin
                if (!click_taken && (gap > {16'd0, cfg.max_interval_ms}))
                begin
                    ev_single        = has_single;
                    click_count_next = 8'd0;
                end
            end
        end
    end

    always_comb
    begin
        result.stable_level = debounced_next;
        result.prior_level  = debounced_reg;
        result.change_event = cfg.events_on && accept && cfg.event_mask[bdg_pkg::MASK_CHANGE];
        result.rise_event   = cfg.events_on && accept && raw
                              && cfg.event_mask[bdg_pkg::MASK_RISE];
        result.fall_event   = cfg.events_on && fall_edge && cfg.event_mask[bdg_pkg::MASK_FALL];
        result.single_event = ev_single;
        result.double_event = ev_double;
        result.long_event   = ev_long;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounced_reg       <= 1'b1;
            prev_raw_reg        <= 1'b1;
            raw_change_time_reg <= 32'd0;
            press_start_reg     <= 32'd0;
            press_pending_reg   <= 1'b0;
            last_click_time_reg <= 32'd0;
            click_count_reg     <= 8'd0;
            long_fired_reg      <= 1'b0;
        end
        else if (advance)
        begin
            debounced_reg       <= debounced_next;
            prev_raw_reg        <= raw;
            raw_change_time_reg <= raw_change_time_next;
            press_start_reg     <= press_start_next;
            press_pending_reg   <= press_pending_next;
            last_click_time_reg <= last_click_time_next;
            click_count_reg     <= click_count_next;
            long_fired_reg      <= long_fired_next;
        end
    end

endmodule

// File: rtl/button_debounce_gesture_detector.sv
// Debounce and gesture detector for one active-low push button.
// Input channel: in_valid / in_stall carry one item per sample, the raw
// pin level and a millisecond timestamp. An item is taken at a rising
// edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry one result item per input
// item: debounced level before and after, and the six event flags.
// Path: input register, step logic, then result register to outputs.
// Throughput: one item per cycle while out_stall is low; the step logic
// between the two registers runs once per item.
// Configuration: APB-style port, registers at byte address 4*index,
// written at psel & penable & pwrite; pready is always high. Write only
// while no item is in flight.
// Reset: rst_n clears the pipeline valids, restores the register reset
// values and puts the button in the released state with no press pending.
// Stall: while out_stall holds a waiting result, one more item is taken
// into the input register; after that in_stall rises until the result
// is taken.
module button_debounce_gesture_detector (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  bdg_pkg::in_item_t          in_item,
    output logic                       out_valid,
    input  logic                       out_stall,
    output bdg_pkg::out_item_t         out_item,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bdg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

`include "button_debounce_gesture_detector_macros.svh"

    bdg_pkg::cfg_t      cfg;
    bdg_pkg::in_item_t  in_item_reg;
    logic               in_valid_reg;
    bdg_pkg::out_item_t out_item_reg;
    logic               out_valid_reg;
    bdg_pkg::out_item_t step_result;
    logic               advance;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    bdg_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bdg_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_item_reg <= step_result;
        end
    end

    `BDG_ASSERT_NOW(a_stall_only_when_full, in_stall, in_valid_reg)
    `BDG_ASSERT_NOW(a_rise_is_edge, out_valid && out_item.rise_event,
                    out_item.stable_level && !out_item.prior_level)
    `BDG_ASSERT_NOW(a_fall_is_edge, out_valid && out_item.fall_event,
                    !out_item.stable_level && out_item.prior_level)
    `BDG_ASSERT_NOW(a_change_is_edge, out_valid && out_item.change_event,
                    out_item.stable_level != out_item.prior_level)

endmodule
